>>> hdl/rfm_pkg.sv
// rfm_pkg: shared types and constants for the reciprocal frequency meter
// used by rfm_ctrl, rfm_datapath and reciprocal_frequency_meter_unit
package rfm_pkg;

  localparam int CLK_BITS     = 27;
  localparam int CAP_IN_BITS  = 24;
  localparam int TALLY_BITS   = 32;
  localparam int OUT_SUM_BITS = 32;
  localparam int FREQ_BITS    = 35;
  localparam int PROD_BITS    = CLK_BITS + TALLY_BITS;
  localparam int ITER_BITS    = $clog2(FREQ_BITS);

  localparam logic [CLK_BITS-1:0]  CLOCK_RESET = 27'd120000000;
  localparam logic [ITER_BITS-1:0] ITER_LAST   = ITER_BITS'(FREQ_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic mul;
    logic check;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic sat;
  } sts_t;

endpackage

>>> hdl/rfm_ctrl.sv
// rfm_ctrl: sequencer for capture updates, tick division and output handshake
// depends on rfm_pkg
module rfm_ctrl
  import rfm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t               state_r, state_nxt;
  logic [ITER_BITS-1:0] iter_r, iter_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.start = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            cmd.capture = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        iter_nxt  = '0;
        state_nxt = sts.sat ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/rfm_datapath.sv
// rfm_datapath: period accumulators, clock register, multiplier, restoring
// divider and result registers; depends on rfm_pkg
module rfm_datapath
  import rfm_pkg::*;
#(
  parameter int CAPTURE_BITS = 24,
  parameter int SUM_BITS     = 32,
  parameter int FRAC_BITS    = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CLK_BITS-1:0]     cfg_wr_data,
  input  logic [CAP_IN_BITS-1:0]  in_capture_count,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [FREQ_BITS-1:0]    out_frequency_q8,
  output logic [OUT_SUM_BITS-1:0] out_period_total,
  output logic [TALLY_BITS-1:0]   out_period_number,
  output logic                    out_valid_res,
  output logic                    out_overflow
);

  localparam int CW     = (CAPTURE_BITS > CAP_IN_BITS) ? CAPTURE_BITS : CAP_IN_BITS;
  localparam int ACC_W  = ((SUM_BITS > CAPTURE_BITS) ? SUM_BITS : CAPTURE_BITS) + 1;
  localparam int PT_W   = (SUM_BITS > OUT_SUM_BITS) ? SUM_BITS : OUT_SUM_BITS;
  localparam int NB     = PROD_BITS + FRAC_BITS;
  localparam int TOP_W  = NB - FREQ_BITS;
  localparam int CMP_W  = (TOP_W > SUM_BITS) ? TOP_W : SUM_BITS;
  localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'({SUM_BITS{1'b1}});

  // accumulators
  logic [CLK_BITS-1:0]     clock_hz_r;
  logic [CAPTURE_BITS-1:0] prev_r;
  logic [SUM_BITS-1:0]     sum_r;
  logic [TALLY_BITS-1:0]   tally_r;
  logic                    flag_r;

  // tick operands
  logic [SUM_BITS-1:0]     den_r;
  logic [TALLY_BITS-1:0]   tally_snap_r;
  logic                    flag_snap_r;
  logic [PROD_BITS-1:0]    prod_r;
  logic                    sat_r;

  // divider
  logic [SUM_BITS-1:0]     rem_r;
  logic [FREQ_BITS-1:0]    low_r;
  logic [FREQ_BITS-1:0]    quo_r;

  logic [CW-1:0]           cap_wide;
  logic [CAPTURE_BITS-1:0] cap;
  logic [CAPTURE_BITS-1:0] period;
  logic [ACC_W-1:0]        acc;
  logic [NB-1:0]           num;
  logic [CMP_W-1:0]        top_ext;
  logic [CMP_W-1:0]        den_ext;
  logic [SUM_BITS:0]       trial;
  logic                    trial_ge;
  logic [PT_W-1:0]         den_wide;
  logic [FREQ_BITS-1:0]    freq;

  assign cap_wide = CW'(in_capture_count);
  assign cap      = cap_wide[CAPTURE_BITS-1:0];
  assign period   = cap - prev_r;
  assign acc      = ACC_W'(sum_r) + ACC_W'(period);

  assign num      = NB'(prod_r) << FRAC_BITS;
  assign top_ext  = CMP_W'(num[NB-1:FREQ_BITS]);
  assign den_ext  = CMP_W'(den_r);
  assign sts.sat  = (top_ext >= den_ext);

  assign trial    = {rem_r, low_r[FREQ_BITS-1]};
  assign trial_ge = (trial >= {1'b0, den_r});
  assign den_wide = PT_W'(den_r);

  always_comb begin
    if (tally_snap_r == '0) begin
      freq = '0;
    end else if (sat_r) begin
      freq = '1;
    end else begin
      freq = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_RESET;
      prev_r     <= '0;
      sum_r      <= '0;
      tally_r    <= '0;
      flag_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_wr_data;
      end
      if (cmd.capture) begin
        prev_r <= cap;
        if (acc > SUM_MAX) begin
          sum_r  <= '1;
          flag_r <= 1'b1;
        end else begin
          sum_r <= acc[SUM_BITS-1:0];
        end
        if (tally_r == '1) begin
          flag_r <= 1'b1;
        end else begin
          tally_r <= tally_r + 1'b1;
        end
      end else if (cmd.start) begin
        sum_r   <= '0;
        tally_r <= '0;
        flag_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      den_r        <= sum_r;
      tally_snap_r <= tally_r;
      flag_snap_r  <= flag_r;
    end
    if (cmd.mul) begin
      prod_r <= clock_hz_r * tally_snap_r;
    end
    if (cmd.check) begin
      sat_r <= sts.sat;
      rem_r <= top_ext[SUM_BITS-1:0];
      low_r <= num[FREQ_BITS-1:0];
      quo_r <= '0;
    end
    if (cmd.step) begin
      rem_r <= trial_ge ? trial[SUM_BITS-1:0] - den_r : trial[SUM_BITS-1:0];
      low_r <= low_r << 1;
      quo_r <= {quo_r[FREQ_BITS-2:0], trial_ge};
    end
    if (cmd.load) begin
      out_frequency_q8  <= freq;
      out_period_total  <= den_wide[OUT_SUM_BITS-1:0];
      out_period_number <= tally_snap_r;
      out_valid_res     <= (tally_snap_r != '0);
      out_overflow      <= flag_snap_r;
    end
  end

endmodule

>>> hdl/reciprocal_frequency_meter_unit.sv
// reciprocal_frequency_meter_unit: top level of the reciprocal frequency meter
// depends on rfm_pkg, rfm_ctrl and rfm_datapath
//
// usage
//   input channel (in_valid/in_ready): in_kind 0 is an edge capture carrying
//   in_capture_count, in_kind 1 is a measurement tick
//   a capture is absorbed and gives no result
//   a tick gives one result on the out_ channel and clears the accumulators
//   a tick passes through one multiply, one range check, one 35-step
//   restoring division at one bit per cycle and the output load; a
//   saturated quotient skips the division
//   throughput: one capture per cycle while no tick is in progress; a tick
//   holds in_ready low until its result is loaded, and the load waits while
//   the output register is still full
//   cfg_wr_en/cfg_wr_data set clock_hz; write only while idle (not enforced)
//   the result waits in an output register; captures keep being taken while
//   the receiver stalls, the next tick finishes and holds until out_ready
//   reset (rst_n low, synchronous) clears the accumulators, the previous
//   capture and the output valid, and sets clock_hz to 120000000
module reciprocal_frequency_meter_unit
  import rfm_pkg::*;
#(
  parameter int CAPTURE_BITS = 24,
  parameter int SUM_BITS     = 32,
  parameter int FRAC_BITS    = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CLK_BITS-1:0]     cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [CAP_IN_BITS-1:0]  in_capture_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FREQ_BITS-1:0]    out_frequency_q8,
  output logic [OUT_SUM_BITS-1:0] out_period_total,
  output logic [TALLY_BITS-1:0]   out_period_number,
  output logic                    out_valid_res,
  output logic                    out_overflow
);

  cmd_t cmd;
  sts_t sts;

  rfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfm_datapath #(
    .CAPTURE_BITS (CAPTURE_BITS),
    .SUM_BITS     (SUM_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_capture_count  (in_capture_count),
    .cmd               (cmd),
    .sts               (sts),
    .out_frequency_q8  (out_frequency_q8),
    .out_period_total  (out_period_total),
    .out_period_number (out_period_number),
    .out_valid_res     (out_valid_res),
    .out_overflow      (out_overflow)
  );

endmodule

>>> verif/tb_reciprocal_frequency_meter_unit.sv
// testbench for reciprocal_frequency_meter_unit: drives capture and tick transactions,
// predicts each frequency reading in place and checks the result channel field by field
// depends on rfm_pkg and the reciprocal_frequency_meter_unit rtl
module tb_reciprocal_frequency_meter_unit
  import rfm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   FRAC          = 8;
  localparam int   SETTLE_CYCLES = 60;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   RANDOM_ITEMS  = 285;
  localparam logic KIND_CAPTURE  = 1'b0;
  localparam logic KIND_TICK     = 1'b1;
  localparam logic [CLK_BITS-1:0] CLOCK_MAX = '1;

  typedef struct packed {
    logic [FREQ_BITS-1:0]    freq;
    logic [OUT_SUM_BITS-1:0] total;
    logic [TALLY_BITS-1:0]   number;
    logic                    vres;
    logic                    ovf;
  } meter_reading_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CLK_BITS-1:0]     cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_kind = 1'b0;
  logic [CAP_IN_BITS-1:0]  in_capture_count = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [FREQ_BITS-1:0]    out_frequency_q8;
  logic [OUT_SUM_BITS-1:0] out_period_total;
  logic [TALLY_BITS-1:0]   out_period_number;
  logic                    out_valid_res;
  logic                    out_overflow;

  logic [CLK_BITS-1:0]     ref_clock_hz = CLOCK_RESET;
  logic [CAP_IN_BITS-1:0]  last_capture = '0;
  logic [OUT_SUM_BITS-1:0] period_acc = '0;
  logic [TALLY_BITS-1:0]   period_cnt = '0;
  logic                    acc_saturated = 1'b0;
  meter_reading_t          pending_readings[$];
  meter_reading_t          want;

  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_out = 1'b0;

  reciprocal_frequency_meter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_capture_count (in_capture_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frequency_q8 (out_frequency_q8),
    .out_period_total (out_period_total),
    .out_period_number(out_period_number),
    .out_valid_res    (out_valid_res),
    .out_overflow     (out_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [FREQ_BITS-1:0] average_frequency(
    input logic [CLK_BITS-1:0] hz, input logic [TALLY_BITS-1:0] cnt,
    input logic [OUT_SUM_BITS-1:0] acc);
    logic [63:0] num, quo, rem;
    if (acc == '0) return '1;
    num = 64'(hz) * 64'(cnt);
    quo = num / 64'(acc);
    rem = num % 64'(acc);
    if (quo >= (64'd1 << (FREQ_BITS - FRAC))) return '1;
    return FREQ_BITS'((quo << FRAC) | ((rem << FRAC) / 64'(acc)));
  endfunction

  task automatic accept_event(input logic kind, input logic [CAP_IN_BITS-1:0] cap);
    logic [CAP_IN_BITS-1:0] period;
    meter_reading_t r;
    if (kind == KIND_CAPTURE) begin
      period = cap - last_capture;
      last_capture = cap;
      if (33'(period) + 33'(period_acc) > 33'(32'hFFFF_FFFF)) begin
        period_acc = '1;
        acc_saturated = 1'b1;
      end else begin
        period_acc = period_acc + 32'(period);
      end
      if (period_cnt == '1) begin
        acc_saturated = 1'b1;
      end else begin
        period_cnt = period_cnt + 1'b1;
      end
    end else begin
      r.vres = (period_cnt != '0);
      r.freq = r.vres ? average_frequency(ref_clock_hz, period_cnt, period_acc) : '0;
      r.total = period_acc;
      r.number = period_cnt;
      r.ovf = acc_saturated;
      pending_readings.push_back(r);
      period_acc = '0;
      period_cnt = '0;
      acc_saturated = 1'b0;
    end
  endtask

  task automatic offer_event(input logic kind, input logic [CAP_IN_BITS-1:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_capture_count <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_event(kind, cap);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock_hz(input logic [CLK_BITS-1:0] hz);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ref_clock_hz = hz;
  endtask

  task automatic compare_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t ns: result transaction with none expected, freq %0h", $time,
                 out_frequency_q8);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("frequency_q8", 64'(want.freq), 64'(out_frequency_q8));
        compare_field("period_total", 64'(want.total), 64'(out_period_total));
        compare_field("period_number", 64'(want.number), 64'(out_period_number));
        compare_field("valid_res", 64'(want.vres), 64'(out_valid_res));
        compare_field("overflow", 64'(want.ovf), 64'(out_overflow));
      end
    end
    out_ready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("reciprocal_frequency_meter_unit: mismatch");
    $finish;
  end

  task automatic test_directed();
    offer_event(KIND_TICK, 24'hFFFFFF);
    offer_event(KIND_CAPTURE, 24'h000000);
    offer_event(KIND_TICK, 24'h000000);
    offer_event(KIND_CAPTURE, 24'h000100);
    offer_event(KIND_CAPTURE, 24'h000300);
    offer_event(KIND_TICK, 24'h5A5A5A);
    offer_event(KIND_CAPTURE, 24'hFFFFF0);
    offer_event(KIND_CAPTURE, 24'h000010);
    offer_event(KIND_TICK, 24'hA5A5A5);
    offer_event(KIND_CAPTURE, 24'hFFFFFF);
    offer_event(KIND_TICK, 24'hFFFFFF);
    offer_event(KIND_CAPTURE, 24'h00000F);
    offer_event(KIND_TICK, 24'h000000);
    write_clock_hz('0);
    offer_event(KIND_CAPTURE, 24'h000400);
    offer_event(KIND_TICK, 24'h123456);
    offer_event(KIND_CAPTURE, 24'h000400);
    offer_event(KIND_TICK, 24'h654321);
    write_clock_hz(CLOCK_MAX);
    offer_event(KIND_CAPTURE, 24'h000400);
    offer_event(KIND_CAPTURE, 24'h000401);
    offer_event(KIND_TICK, 24'h000000);
    offer_event(KIND_CAPTURE, 24'h000402);
    offer_event(KIND_TICK, 24'hFFFFFF);
    write_clock_hz(CLK_BITS'(1));
    offer_event(KIND_CAPTURE, 24'h000401);
    offer_event(KIND_TICK, 24'h000000);
    offer_event(KIND_CAPTURE, 24'h000481);
    offer_event(KIND_TICK, 24'hFFFFFF);
  endtask

  // each capture one count below the last gives the longest period
  task automatic test_sum_saturation();
    write_clock_hz(CLOCK_RESET);
    repeat (260) offer_event(KIND_CAPTURE, last_capture - 1'b1);
    offer_event(KIND_TICK, 24'($urandom));
    offer_event(KIND_CAPTURE, last_capture + 24'h000800);
    offer_event(KIND_TICK, 24'($urandom));
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    repeat (6) begin
      repeat (4) offer_event(KIND_CAPTURE, last_capture + 24'($urandom_range(1, 5000)));
      offer_event(KIND_TICK, 24'($urandom));
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int sent, burst, mode;
    logic [CAP_IN_BITS-1:0] step;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 65;
          write_clock_hz(CLK_BITS'($urandom));
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 26;
          write_clock_hz(CLK_BITS'($urandom_range(1, 1000)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_clock_hz(CLOCK_RESET);
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
        burst = $urandom_range(0, 12);
        mode = $urandom_range(0, 3);
        repeat (burst) begin
          case (mode)
            0:       step = 24'($urandom_range(0, 15));
            1:       step = 24'($urandom_range(16, 4095));
            2:       step = 24'($urandom_range(4096, 24'hFFFFFF));
            default: step = 24'($urandom);
          endcase
          offer_event(KIND_CAPTURE, (mode == 3) ? step
                                   : last_capture + step + 24'($urandom_range(0, 3)));
          sent++;
        end
        offer_event(KIND_TICK, 24'($urandom));
        sent++;
        if ($urandom_range(9) == 0) begin
          offer_event(KIND_TICK, 24'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 26;
    recv_idle_pct = 65;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sum_saturation();
    test_output_backpressure();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("reciprocal_frequency_meter_unit: match");
    end else begin
      $display("reciprocal_frequency_meter_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rfm_pkg.sv
hdl/rfm_ctrl.sv
hdl/rfm_datapath.sv
hdl/reciprocal_frequency_meter_unit.sv
verif/tb_reciprocal_frequency_meter_unit.sv
